// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the bind-variable filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked assertion that is also checked during reset.
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif

`endif

// ===== hdl/sbvf_pkg.sv =====
// Types, character constants and helper functions of the bind-variable filter.
`default_nettype none

package sbvf_pkg;

  // Configuration port address width and register index decode.
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam logic        REG_STRIP_MODE = 1'b0;

  // Characters the scanner recognizes.
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Scanner states.
  typedef enum logic [2:0] {
    ST_PLAIN  = 3'd0,
    ST_QUOTED = 3'd1,
    ST_NAME   = 3'd2,
    ST_SPEC   = 3'd3,
    ST_COLON  = 3'd4
  } scan_t;

  // One input transaction held in the input register.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  // The burst of up to three result bytes caused by one input byte.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            no_byte;
    logic            eot;
  } burst_t;

  // Append one byte to a burst; a full burst is left unchanged.
  function automatic burst_t push(burst_t bi, logic [7:0] b);
    burst_t r;
    r = bi;
    if (r.cnt != 2'd3) begin
      r.bytes[r.cnt] = b;
      r.cnt          = r.cnt + 2'd1;
    end
    return r;
  endfunction

  // ASCII letters and digits continue a bind name.
  function automatic logic is_name_char(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h30) && (b <= 8'h39));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sbvf_in_if.sv =====
// Input stream interface: one SQL text byte per transaction.
`default_nettype none

interface sbvf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbvf_out_if.sv =====
// Result stream interface: one filtered byte or end marker per transaction.
`default_nettype none

interface sbvf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       no_byte;
  logic       final_result;

  modport source (output valid, out_byte, no_byte, final_result, input ready);
  modport sink   (input valid, out_byte, no_byte, final_result, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbvf_scanner.sv =====
// Scanner state and the combinational step that turns one byte into a burst.
`default_nettype none

module sbvf_scanner (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire sbvf_pkg::item_t item,
  input  wire logic            strip_mode,
  output sbvf_pkg::burst_t     burst
);
  import sbvf_pkg::*;

  scan_t  state_r, state_nxt;
  logic   qdbl_r, qdbl_nxt;
  logic   do_name, do_plain;
  logic   [7:0] b;
  burst_t bst;

  assign b = item.text_byte;

  // Next state and emitted bytes for the byte in the input register.
  always_comb begin
    state_nxt = state_r;
    qdbl_nxt  = qdbl_r;
    do_name   = 1'b0;
    do_plain  = 1'b0;
    bst       = '0;

    unique case (state_r)
      ST_QUOTED: begin
        bst = push(bst, b);
        if (b == (qdbl_r ? CH_DQUOTE : CH_SQUOTE)) state_nxt = ST_PLAIN;
      end
      ST_COLON: begin
        if (b == CH_COLON) begin
          bst       = push(bst, CH_COLON);
          bst       = push(bst, CH_COLON);
          state_nxt = ST_PLAIN;
        end else begin
          bst     = push(bst, CH_SQUOTE);
          bst     = push(bst, CH_SQUOTE);
          do_name = 1'b1;
        end
      end
      ST_NAME: begin
        do_name = 1'b1;
      end
      ST_SPEC: begin
        if (!strip_mode) bst = push(bst, CH_SPACE);
        if (b == CH_GT) state_nxt = ST_PLAIN;
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // Inside a name: continue it, open a specifier, or fall back to plain text.
    if (do_name) begin
      if (is_name_char(b)) begin
        if (!strip_mode) bst = push(bst, b);
        state_nxt = ST_NAME;
      end else if (b == CH_LT) begin
        if (!strip_mode) bst = push(bst, CH_SPACE);
        state_nxt = ST_SPEC;
      end else begin
        do_plain = 1'b1;
      end
    end

    // Plain text handling.
    if (do_plain) begin
      state_nxt = ST_PLAIN;
      if (b == CH_SQUOTE) begin
        bst       = push(bst, b);
        state_nxt = ST_QUOTED;
        qdbl_nxt  = 1'b0;
      end else if (b == CH_DQUOTE) begin
        bst       = push(bst, b);
        state_nxt = ST_QUOTED;
        qdbl_nxt  = 1'b1;
      end else if (b == CH_COLON) begin
        if (!strip_mode) begin
          bst       = push(bst, b);
          state_nxt = ST_NAME;
        end else begin
          state_nxt = ST_COLON;
        end
      end else begin
        bst = push(bst, b);
      end
    end

    // A colon still pending at the end of text becomes two quotes.
    if (item.end_of_text && (state_nxt == ST_COLON)) begin
      bst = push(bst, CH_SQUOTE);
      bst = push(bst, CH_SQUOTE);
    end

    // End of text: mark the last result and return to the reset state.
    if (item.end_of_text) begin
      if (bst.cnt == 2'd0) begin
        bst.no_byte = 1'b1;
        bst.cnt     = 2'd1;
      end
      bst.eot   = 1'b1;
      state_nxt = ST_PLAIN;
      qdbl_nxt  = 1'b0;
    end
  end

  assign burst = bst;

  // Scanner state advances when the byte moves on to the burst register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PLAIN;
      qdbl_r  <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
      qdbl_r  <= qdbl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sql_bind_variable_filter.sv =====
// SQL bind-variable filter: one text byte in, zero to three filtered bytes out.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver is ready; a byte that yields more results holds the burst
// register until the receiver has taken the last of them.
// Reset (synchronous, rst_n low) empties both registers, returns the scanner to
// plain text and clears strip_mode.
`default_nettype none
`include "assert_macros.svh"

module sql_bind_variable_filter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sbvf_in_if.sink                            in_chan,
  sbvf_out_if.source                         out_chan,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sbvf_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import sbvf_pkg::*;

  logic   strip_mode_r;
  logic   in_v_r;
  item_t  item_r;
  logic   burst_v_r;
  burst_t burst_r;
  logic   [1:0] idx_r;
  burst_t scan_burst;
  logic   move, last, out_fire, cfg_wr;

  // Configuration port: single register at index zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_STRIP_MODE) ? {31'd0, strip_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_mode_r <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_STRIP_MODE)) begin
      strip_mode_r <= pwdata[0];
    end
  end

  // Handshake control between input register and burst register.
  assign out_fire      = burst_v_r && out_chan.ready;
  assign last          = (idx_r == (burst_r.cnt - 2'd1));
  assign move          = in_v_r && (!burst_v_r || (out_fire && last));
  assign in_chan.ready = !in_v_r || move;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.text_byte   <= in_chan.text_byte;
      item_r.end_of_text <= in_chan.end_of_text;
    end
  end

  sbvf_scanner u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (move),
    .item       (item_r),
    .strip_mode (strip_mode_r),
    .burst      (scan_burst)
  );

  // Burst register and the index of the result on offer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_v_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (move) begin
      burst_v_r <= (scan_burst.cnt != 2'd0);
      idx_r     <= 2'd0;
    end else if (out_fire) begin
      if (last) begin
        burst_v_r <= 1'b0;
        idx_r     <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      burst_r <= scan_burst;
    end
  end

  // Result transaction.
  assign out_chan.valid        = burst_v_r;
  assign out_chan.out_byte     = burst_r.bytes[idx_r];
  assign out_chan.no_byte      = burst_r.no_byte;
  assign out_chan.final_result = burst_r.eot && last;

  // Checks on the burst sequencing.
  `ASSERT_AT(a_idx_in_burst, clk, rst_n, burst_v_r |-> (idx_r < burst_r.cnt))
  `ASSERT_AT(a_idx_step, clk, rst_n, (out_fire && !last) |=> (burst_v_r && (idx_r == ($past(idx_r) + 2'd1))))
  `ASSERT_AT(a_marker_alone, clk, rst_n, (burst_v_r && burst_r.no_byte) |-> (burst_r.eot && (burst_r.cnt == 2'd1)))
  `ASSERT_NORST(a_reset_empty, clk, !rst_n |=> (!burst_v_r && !in_v_r))

endmodule

`default_nettype wire

// ===== tb/sql_bind_variable_filter_tb.sv =====
// Self-checking testbench of the bind-variable filter: directed table, then random statements.
`timescale 1ns / 1ps

module sql_bind_variable_filter_tb;
  import sbvf_pkg::*;

  // Register 0 of the configuration port sits at byte address 0.
  localparam logic [CFG_ADDR_W-1:0] ADDR_STRIP_MODE = '0;
  localparam int MAX_RESULTS  = 3;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 60;

  // One filtered byte as it leaves the block.
  typedef struct packed {
    logic [7:0] ch;
    logic       no_byte;
    logic       last;
  } filtered_t;

  // One stimulus row; typed rows carry their results, the others are predicted.
  typedef struct packed {
    logic       strip;
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic [1:0] n_typed;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sbvf_in_if  in_if ();
  sbvf_out_if out_if ();

  sql_bind_variable_filter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state, kept in step with the block.
  scan_t      scan_st    = ST_PLAIN;
  logic       dq_open    = 1'b0;
  logic       strip_mode = 1'b0;
  logic [7:0] burst_q[$];
  filtered_t  predicted_q[$];
  filtered_t  filtered_q[$];
  filtered_t  oldest;

  int error_count   = 0;
  int items_fed     = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 86;

  // Directed rows: extremes, strings, specifiers, casts and the end-of-text cases.
  stim_row_t directed_rows [25] = '{
    '{1'b0, 8'h00,     1'b0, 1'b1, 2'd1, 8'h00,      8'h00,     8'h00},
    '{1'b0, 8'hFF,     1'b0, 1'b1, 2'd1, 8'hFF,      8'h00,     8'h00},
    '{1'b0, CH_COLON,  1'b0, 1'b1, 2'd1, CH_COLON,   8'h00,     8'h00},
    '{1'b0, "Z",       1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    // A Latin-1 letter ends the name and passes as plain text.
    '{1'b0, 8'hE9,     1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b0, CH_COLON,  1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b0, CH_LT,     1'b0, 1'b1, 2'd1, CH_SPACE,   8'h00,     8'h00},
    '{1'b0, CH_GT,     1'b0, 1'b1, 2'd1, CH_SPACE,   8'h00,     8'h00},
    '{1'b0, CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b0, CH_DQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b0, CH_SQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b0, CH_DQUOTE, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b0, CH_DQUOTE, 1'b1, 1'b1, 2'd1, CH_DQUOTE,  8'h00,     8'h00},
    '{1'b0, CH_COLON,  1'b1, 1'b1, 2'd1, CH_COLON,   8'h00,     8'h00},
    // Replace mode: a colon waits for the next byte.
    '{1'b1, CH_COLON,  1'b0, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b1, CH_COLON,  1'b0, 1'b1, 2'd2, CH_COLON,   CH_COLON,  8'h00},
    '{1'b1, CH_COLON,  1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b1, "b",       1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b1, CH_LT,     1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    // The last byte yields nothing, so only the end marker comes out.
    '{1'b1, CH_GT,     1'b1, 1'b1, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b1, CH_COLON,  1'b1, 1'b1, 2'd2, CH_SQUOTE,  CH_SQUOTE, 8'h00},
    '{1'b1, CH_COLON,  1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b1, CH_SQUOTE, 1'b1, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    // A pending colon survives a switch back to blank mode.
    '{1'b1, CH_COLON,  1'b0, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00},
    '{1'b0, "a",       1'b1, 1'b0, 2'd0, 8'h00,      8'h00,     8'h00}
  };

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Only ASCII letters and digits continue a bind name.
  function automatic logic bind_name_char(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9");
  endfunction

  // A byte seen outside strings, names and specifiers.
  function automatic void plain_char(input logic [7:0] b);
    scan_st = ST_PLAIN;
    if (b == CH_SQUOTE) begin
      burst_q.push_back(b);
      scan_st = ST_QUOTED;
      dq_open = 1'b0;
    end else if (b == CH_DQUOTE) begin
      burst_q.push_back(b);
      scan_st = ST_QUOTED;
      dq_open = 1'b1;
    end else if (b == CH_COLON) begin
      if (!strip_mode) begin
        burst_q.push_back(b);
        scan_st = ST_NAME;
      end else begin
        scan_st = ST_COLON;
      end
    end else begin
      burst_q.push_back(b);
    end
  endfunction

  // A byte after a colon or inside a name.
  function automatic void name_char(input logic [7:0] b);
    if (bind_name_char(b)) begin
      if (!strip_mode) burst_q.push_back(b);
      scan_st = ST_NAME;
    end else if (b == CH_LT) begin
      if (!strip_mode) burst_q.push_back(CH_SPACE);
      scan_st = ST_SPEC;
    end else begin
      plain_char(b);
    end
  endfunction

  // Turn the burst into results and mark the end of the statement.
  function automatic void close_burst(input logic eot);
    filtered_t r;
    predicted_q.delete();
    foreach (burst_q[i]) begin
      if (i < MAX_RESULTS) begin
        r.ch      = burst_q[i];
        r.no_byte = 1'b0;
        r.last    = 1'b0;
        predicted_q.push_back(r);
      end
    end
    if (eot) begin
      if (predicted_q.size() == 0) begin
        r.ch      = 8'h00;
        r.no_byte = 1'b1;
        r.last    = 1'b0;
        predicted_q.push_back(r);
      end
      predicted_q[predicted_q.size() - 1].last = 1'b1;
    end
  endfunction

  // Predict the results of one text byte and advance the scanner.
  function automatic void filter_byte(input logic [7:0] b, input logic eot);
    burst_q.delete();
    case (scan_st)
      ST_QUOTED: begin
        burst_q.push_back(b);
        if (b == (dq_open ? CH_DQUOTE : CH_SQUOTE)) scan_st = ST_PLAIN;
      end
      ST_COLON: begin
        if (b == CH_COLON) begin
          burst_q.push_back(CH_COLON);
          burst_q.push_back(CH_COLON);
          scan_st = ST_PLAIN;
        end else begin
          burst_q.push_back(CH_SQUOTE);
          burst_q.push_back(CH_SQUOTE);
          name_char(b);
        end
      end
      ST_NAME: name_char(b);
      ST_SPEC: begin
        if (!strip_mode) burst_q.push_back(CH_SPACE);
        if (b == CH_GT) scan_st = ST_PLAIN;
      end
      default: plain_char(b);
    endcase
    if (eot && scan_st == ST_COLON) begin
      burst_q.push_back(CH_SQUOTE);
      burst_q.push_back(CH_SQUOTE);
    end
    close_burst(eot);
    if (eot) begin
      scan_st = ST_PLAIN;
      dq_open = 1'b0;
    end
  endfunction

  function automatic logic [7:0] random_name_char();
    case ($urandom_range(0, 2))
      0:       return 8'("A" + $urandom_range(0, 25));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    // Keep the log short when the block is badly off.
    if (error_count <= 100) $display("%0t ns: %s", $time, msg);
  endtask

  // Offer one byte, wait for its transaction, then queue what it should yield.
  task automatic feed(input stim_row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.text_byte   <= row.ch;
    in_if.end_of_text <= row.last;
    do @(posedge clk); while (!in_if.ready);
    items_fed++;
    filter_byte(row.ch, row.last);
    if (row.typed) begin
      burst_q.delete();
      if (row.n_typed > 0) burst_q.push_back(row.r0);
      if (row.n_typed > 1) burst_q.push_back(row.r1);
      if (row.n_typed > 2) burst_q.push_back(row.r2);
      close_burst(row.last);
    end
    foreach (predicted_q[i]) filtered_q.push_back(predicted_q[i]);
  endtask

  // Stop sending and let every expected result come out.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write strip_mode through the configuration port: setup, then access.
  task automatic write_strip_mode(input logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_STRIP_MODE;
    pwdata  <= {31'd0, mode};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    strip_mode = mode;
  endtask

  // One random statement: mostly quoted strings, bind variables and casts.
  task automatic send_statement();
    logic [7:0] stmt[$];
    logic [7:0] qc;
    stim_row_t  row;
    if ($urandom_range(0, 7) == 0) begin
      // Raw noise with no structure.
      repeat ($urandom_range(1, 6)) stmt.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 6))
          0: stmt.push_back(8'($urandom_range(32, 126)));
          1: begin
            qc = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            stmt.push_back(qc);
            repeat ($urandom_range(0, 4)) stmt.push_back(8'($urandom_range(32, 126)));
            // Mostly closed; an open string runs to the end of the statement.
            if ($urandom_range(0, 4) != 0) stmt.push_back(qc);
          end
          2, 3: begin
            stmt.push_back(CH_COLON);
            repeat ($urandom_range(1, 4)) stmt.push_back(random_name_char());
            if ($urandom_range(0, 1)) begin
              stmt.push_back(CH_LT);
              repeat ($urandom_range(0, 3)) stmt.push_back(8'($urandom_range(0, 255)));
              if ($urandom_range(0, 5) != 0) stmt.push_back(CH_GT);
            end
          end
          4: begin
            // Cast, optionally followed by a type name.
            stmt.push_back(CH_COLON);
            stmt.push_back(CH_COLON);
            repeat ($urandom_range(0, 3)) stmt.push_back(random_name_char());
          end
          5: begin
            // Bind name ended by an arbitrary byte.
            stmt.push_back(CH_COLON);
            repeat ($urandom_range(0, 3)) stmt.push_back(random_name_char());
            stmt.push_back(8'($urandom_range(0, 255)));
          end
          default: stmt.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    foreach (stmt[i]) begin
      row = '{strip_mode, stmt[i], (i == stmt.size() - 1), 1'b0, 2'd0, 8'h00, 8'h00, 8'h00};
      feed(row);
    end
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: byte %02h no_byte %0b final %0b",
                                  out_if.out_byte, out_if.no_byte, out_if.final_result));
      end else begin
        oldest = filtered_q.pop_front();
        if (out_if.out_byte !== oldest.ch || out_if.no_byte !== oldest.no_byte ||
            out_if.final_result !== oldest.last) begin
          report_mismatch($sformatf("got byte %02h no_byte %0b final %0b, want %02h %0b %0b",
                                    out_if.out_byte, out_if.no_byte, out_if.final_result,
                                    oldest.ch, oldest.no_byte, oldest.last));
        end
      end
    end
  end

  // Stimulus: reset, directed table, then three random phases.
  initial begin
    int ph;
    int target;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.text_byte   <= 8'h00;
    in_if.end_of_text <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= 32'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].strip != strip_mode) begin
        settle();
        write_strip_mode(directed_rows[r].strip);
      end
      feed(directed_rows[r]);
    end

    // Receiver-heavy idling, then sender-heavy, then none.
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 86 : 0;
      recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 35 : 0;
      settle();
      write_strip_mode(ph != 1);
      target = items_fed + PHASE_ITEMS;
      while (items_fed < target) begin
        // In the last phase the mode also flips between statements.
        if (ph == 2 && $urandom_range(0, 3) == 0) begin
          settle();
          write_strip_mode($urandom_range(0, 1));
        end
        send_statement();
      end
    end

    settle();
    if (error_count == 0) begin
      $display("sql_bind_variable_filter: match");
    end else begin
      $display("sql_bind_variable_filter: mismatch");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("sql_bind_variable_filter: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sbvf_pkg.sv
hdl/sbvf_in_if.sv
hdl/sbvf_out_if.sv
hdl/sbvf_scanner.sv
hdl/sql_bind_variable_filter.sv
tb/sql_bind_variable_filter_tb.sv
